/* rtl/core/mics_pkg.sv */
// Shared constants and types of the Moyal inverse-CDF sampler.
package mics_pkg;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LOCATION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 8'd1;

  localparam int T_W   = 40;  // signed Q32 working values (t, L, ln)
  localparam int LOG_W = 38;  // log2 result: 6 integer bits, 32 fraction bits
  localparam int P_W   = 64;  // polynomial value, Q56

  localparam logic signed [32:0] LN2_Q32   = 33'sd2977044472;
  localparam logic signed [39:0] TAIL_LIM  = 40'sd26306674688;
  localparam logic [39:0] T_OFFSET         = 40'd64 << 32;
  localparam logic [39:0] L_OFFSET         = 40'd88 << 32;
  localparam logic [39:0] HALF_Q32         = 40'd1 << 31;

  localparam logic signed [31:0] SAMPLE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAMPLE_MIN = 32'sh80000000;

  localparam logic signed [63:0] MID_C [10] = '{
    64'sh175c000 << 4,  64'sh133b402 << 9,  64'sh1499232 << 12,
    64'sh1e52cd2 << 8,  -(64'sh1d70bd0 << 17), -(64'sh135be90 << 19),
    64'sh12f6400 << 23, 64'sh17a1e50 << 25, -(64'sh1db2aee << 29),
    64'sh1c5bf88 << 31
  };

  localparam logic signed [63:0] TAIL_C [9] = '{
    64'sh14deb44,       64'sh1f7c9ae << 6,  64'sh147e512 << 12,
    64'sh1dca7de << 16, 64'sh19cab92 << 20, 64'sh18cc0de << 23,
    64'sh13ca920 << 24, -(64'sh10eff66 << 30), 64'sh1ae16a4 << 31
  };

  typedef struct packed {
    logic [31:0] sample;
    logic        sat;
  } res_t;

endpackage

/* rtl/core/mics_log2_cell.sv */
// One squaring step of the bit-by-bit log2 fraction extraction.
module mics_log2_cell #(
  parameter int IDX = 0,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [31:0]   in_m,
  input  logic [31:0]   in_frac,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [31:0]   out_m,
  output logic [31:0]   out_frac,
  output logic [SW-1:0] out_side
);

  logic [63:0]   sq;
  logic [32:0]   sq_top;
  logic [31:0]   m_nxt;
  logic [31:0]   frac_nxt;
  logic          vld_r;
  logic [31:0]   m_r;
  logic [31:0]   frac_r;
  logic [SW-1:0] side_r;

  always_comb begin
    sq     = 64'(in_m) * 64'(in_m);
    sq_top = sq[63:31];
    if (sq_top[32]) begin
      m_nxt    = sq_top[32:1];
      frac_nxt = in_frac | (32'd1 << (31 - IDX));
    end else begin
      m_nxt    = sq_top[31:0];
      frac_nxt = in_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      frac_r <= frac_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_m    = m_r;
  assign out_frac = frac_r;
  assign out_side = side_r;

endmodule

/* rtl/core/mics_log2.sv */
// Pipelined log2 of a 64-bit integer: normalisation then a row of 32 squaring cells.
module mics_log2 #(
  parameter int SW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [63:0]                in_val,
  input  logic [SW-1:0]              in_side,
  output logic                       out_vld,
  output logic [mics_pkg::LOG_W-1:0] out_log,
  output logic [SW-1:0]              out_side
);
  import mics_pkg::*;

  localparam int CW = SW + 6;

  logic          v1_r;
  logic [63:0]   val_r;
  logic [SW-1:0] side1_r;
  logic [5:0]    lz;
  logic [63:0]   norm;
  logic          v2_r;
  logic [31:0]   m2_r;
  logic [CW-1:0] side2_r;

  logic          vld_w  [33];
  logic [31:0]   m_w    [33];
  logic [31:0]   frac_w [33];
  logic [CW-1:0] side_w [33];

  // Leading-zero count of the registered value.
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (val_r[i]) begin
        lz = 6'(63 - i);
      end
    end
    norm = val_r << lz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r   <= in_val;
      side1_r <= in_side;
      m2_r    <= norm[63:32];
      side2_r <= {6'd63 - lz, side1_r};
    end
  end

  assign vld_w[0]  = v2_r;
  assign m_w[0]    = m2_r;
  assign frac_w[0] = '0;
  assign side_w[0] = side2_r;

  for (genvar g = 0; g < 32; g++) begin : g_cell
    mics_log2_cell #(.IDX(g), .SW(CW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld_w[g]),
      .in_m     (m_w[g]),
      .in_frac  (frac_w[g]),
      .in_side  (side_w[g]),
      .out_vld  (vld_w[g+1]),
      .out_m    (m_w[g+1]),
      .out_frac (frac_w[g+1]),
      .out_side (side_w[g+1])
    );
  end

  assign out_vld  = vld_w[32];
  assign out_log  = {side_w[32][CW-1:SW], frac_w[32]};
  assign out_side = side_w[32][SW-1:0];

endmodule

/* rtl/core/mics_mulsh.sv */
// Signed product with a rounding right shift, half away from zero, in three stages.
module mics_mulsh #(
  parameter int AW = 40,
  parameter int BW = 33,
  parameter int S  = 32,
  parameter int RW = 40,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [AW-1:0] in_a,
  input  logic signed [BW-1:0] in_b,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic signed [RW-1:0] out_res,
  output logic [SW-1:0]        out_side
);

  localparam int PW = AW + BW;

  logic [2:0]           vld_r;
  logic                 neg1_r, neg2_r;
  logic [AW-1:0]        ma_r;
  logic [BW-1:0]        mb_r;
  logic [PW-1:0]        prod_r;
  logic [SW-1:0]        side1_r, side2_r, side3_r;
  logic [PW:0]          rnd;
  logic [PW:0]          shr;
  logic [RW-1:0]        mag;
  logic signed [RW-1:0] res_nxt;
  logic signed [RW-1:0] res_r;

  always_comb begin
    rnd     = {1'b0, prod_r} + ((PW + 1)'(1) << (S - 1));
    shr     = rnd >> S;
    // The magnitude is limited to 63 bits before the sign is applied.
    mag     = RW'(shr[62:0]);
    res_nxt = neg2_r ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= in_a[AW-1] ^ in_b[BW-1];
      ma_r    <= in_a[AW-1] ? AW'(-in_a) : AW'(in_a);
      mb_r    <= in_b[BW-1] ? BW'(-in_b) : BW'(in_b);
      side1_r <= in_side;
      neg2_r  <= neg1_r;
      prod_r  <= PW'(ma_r) * PW'(mb_r);
      side2_r <= side1_r;
      res_r   <= res_nxt;
      side3_r <= side2_r;
    end
  end

  assign out_vld  = vld_r[2];
  assign out_res  = res_r;
  assign out_side = side3_r;

endmodule

/* rtl/core/mics_horner_cell.sv */
// One Horner step p = rnd(p*t / 2^32) + c, split over two stages.
module mics_horner_cell #(
  parameter int K  = 1,
  parameter int SW = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [mics_pkg::P_W-1:0] in_p,
  input  logic signed [mics_pkg::T_W-1:0] in_t,
  input  logic                           in_tail,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_vld,
  output logic signed [mics_pkg::P_W-1:0] out_p,
  output logic signed [mics_pkg::T_W-1:0] out_t,
  output logic                           out_tail,
  output logic [SW-1:0]                  out_side
);
  import mics_pkg::*;

  logic [P_W-1:0]        magp;
  logic [T_W-1:0]        magt;
  logic [1:0]            vld_r;
  logic                  neg_r;
  logic [71:0]           pl_r, ph_r;
  logic signed [T_W-1:0] t1_r, t2_r;
  logic                  tail1_r, tail2_r;
  logic [SW-1:0]         side1_r, side2_r;
  logic [103:0]          full;
  logic [63:0]           rmag;
  logic [63:0]           pv;
  logic signed [63:0]    coef;
  logic [63:0]           p_nxt;
  logic [63:0]           p_r;

  always_comb begin
    magp = in_p[P_W-1] ? P_W'(-in_p) : P_W'(in_p);
    magt = in_t[T_W-1] ? T_W'(-in_t) : T_W'(in_t);
  end

  // The tail polynomial has one coefficient fewer and enters one step later.
  always_comb begin
    coef  = tail1_r ? TAIL_C[K-1] : MID_C[K];
    full  = {ph_r, 32'd0} + 104'(pl_r) + (104'd1 << 31);
    rmag  = {1'b0, full[94:32]};
    pv    = neg_r ? (64'd0 - rmag) : rmag;
    p_nxt = pv + coef;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r   <= in_p[P_W-1] ^ in_t[T_W-1];
      pl_r    <= 72'(magp[31:0]) * 72'(magt);
      ph_r    <= 72'(magp[63:32]) * 72'(magt);
      t1_r    <= in_t;
      tail1_r <= in_tail;
      side1_r <= in_side;
      p_r     <= p_nxt;
      t2_r    <= t1_r;
      tail2_r <= tail1_r;
      side2_r <= side1_r;
    end
  end

  assign out_vld  = vld_r[1];
  assign out_p    = $signed(p_r);
  assign out_t    = t2_r;
  assign out_tail = tail2_r;
  assign out_side = side2_r;

endmodule

/* rtl/core/moyal_inverse_cdf_sampler.sv */
// Top level of the Moyal inverse-CDF sampler: log, polynomial and scaling pipeline.
//
//  port group  direction  transaction content
//  in_*        input      in_uniform_fraction (u times 2^32)
//  out_*       output     out_sample_value (signed Q16.16), out_saturated
//  cfg_*       input      cfg_index (0 location, 1 scale), cfg_data
//
// One sample is accepted every cycle unless the pipeline holds; the path from acceptance to
// out_valid runs through the two 32-cell log2 rows and the nine two-stage Horner cells.
// Reset clears all valid bits and the two-entry output queue and loads the
// default location and scale. When the queue is full and a result reaches its
// end, the whole pipeline holds and in_ready drops.
module moyal_inverse_cdf_sampler #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_uniform_fraction,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_sample_value,
  output logic                           out_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mics_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import mics_pkg::*;

  logic signed [31:0] loc_r;
  logic [31:0]        scale_r;
  logic               en;

  // Stage inputs
  logic        zero_in;
  logic [32:0] a_in;
  logic [33:0] w_in;

  // First log pair
  logic             l1_vld;
  logic [LOG_W-1:0] lu, lw;
  logic             l1_zero;
  logic [32:0]      l1_a;
  logic signed [T_W-1:0] s_w;

  // t
  logic                  t_vld;
  logic signed [T_W-1:0] t_w;
  logic [33:0]           t_side;
  logic                  tail_w;

  // Horner row
  logic                  h_vld  [10];
  logic signed [P_W-1:0] h_p    [10];
  logic signed [T_W-1:0] h_t    [10];
  logic                  h_tail [10];
  logic [33:0]           h_side [10];

  // Second log pair
  logic             nonpos;
  logic             l2_vld;
  logic [LOG_W-1:0] lp, la;
  logic             l2_zero, l2_np;
  logic signed [T_W-1:0] lsum;

  logic                  m_vld;
  logic signed [T_W-1:0] lnv;
  logic [1:0]            m_side;
  logic                  d_vld;
  logic signed [47:0]    d_w;
  logic [1:0]            d_side;
  logic signed [48:0]    x_w;
  res_t                  res_nxt;

  // Output queue
  res_t       q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push, pop;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r   <= '0;
      scale_r <= 32'd1 << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCATION: loc_r   <= $signed(cfg_data);
        REG_SCALE:    scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !(cnt_r == 2'd2 && d_vld);
  assign in_ready = en;

  assign zero_in = (in_uniform_fraction == 32'd0);
  assign a_in    = 33'd1 << 32;
  assign w_in    = (34'd1 << 33) - 34'(in_uniform_fraction);

  mics_log2 #(.SW(1)) u_log_u (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld   (in_valid && in_ready),
    .in_val   (64'(in_uniform_fraction)),
    .in_side  (zero_in),
    .out_vld  (l1_vld),
    .out_log  (lu),
    .out_side (l1_zero)
  );

  mics_log2 #(.SW(33)) u_log_w (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld   (in_valid && in_ready),
    .in_val   (64'(w_in)),
    .in_side  (a_in - 33'(in_uniform_fraction)),
    .out_vld  (),
    .out_log  (lw),
    .out_side (l1_a)
  );

  // log2(1 - a*a) in Q32, before the conversion to a natural log.
  assign s_w = $signed(40'(lu) + 40'(lw) - T_OFFSET);

  mics_mulsh #(.AW(T_W), .BW(33), .S(32), .RW(T_W), .SW(34)) u_mul_t (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld   (l1_vld),
    .in_a     (s_w),
    .in_b     (LN2_Q32),
    .in_side  ({l1_zero, l1_a}),
    .out_vld  (t_vld),
    .out_res  (t_w),
    .out_side (t_side)
  );

  assign tail_w = (t_w < -TAIL_LIM);

  assign h_vld[0]  = t_vld;
  assign h_p[0]    = tail_w ? 64'sd0 : MID_C[0];
  assign h_t[0]    = t_w;
  assign h_tail[0] = tail_w;
  assign h_side[0] = t_side;

  for (genvar g = 1; g < 10; g++) begin : g_horner
    mics_horner_cell #(.K(g), .SW(34)) u_cell (
      .clk (clk), .rst_n (rst_n), .en (en),
      .in_vld   (h_vld[g-1]),
      .in_p     (h_p[g-1]),
      .in_t     (h_t[g-1]),
      .in_tail  (h_tail[g-1]),
      .in_side  (h_side[g-1]),
      .out_vld  (h_vld[g]),
      .out_p    (h_p[g]),
      .out_t    (h_t[g]),
      .out_tail (h_tail[g]),
      .out_side (h_side[g])
    );
  end

  assign nonpos = h_p[9][P_W-1] || (h_p[9] == 64'sd0);

  mics_log2 #(.SW(1)) u_log_p (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld   (h_vld[9]),
    .in_val   (64'(h_p[9])),
    .in_side  (h_side[9][33]),
    .out_vld  (l2_vld),
    .out_log  (lp),
    .out_side (l2_zero)
  );

  mics_log2 #(.SW(1)) u_log_a (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld   (h_vld[9]),
    .in_val   (64'(h_side[9][32:0])),
    .in_side  (nonpos),
    .out_vld  (),
    .out_log  (la),
    .out_side (l2_np)
  );

  assign lsum = $signed(40'(la) + 40'(lp) + HALF_Q32 - L_OFFSET);

  mics_mulsh #(.AW(T_W), .BW(33), .S(32), .RW(T_W), .SW(2)) u_mul_ln (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld   (l2_vld),
    .in_a     (lsum),
    .in_b     (LN2_Q32),
    .in_side  ({l2_zero, l2_np}),
    .out_vld  (m_vld),
    .out_res  (lnv),
    .out_side (m_side)
  );

  mics_mulsh #(.AW(33), .BW(T_W), .S(31), .RW(48), .SW(2)) u_mul_d (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld   (m_vld),
    .in_a     ($signed({1'b0, scale_r})),
    .in_b     (lnv),
    .in_side  (m_side),
    .out_vld  (d_vld),
    .out_res  (d_w),
    .out_side (d_side)
  );

  always_comb begin
    x_w = 49'(loc_r) - 49'(d_w);
    if (d_side[1]) begin
      res_nxt = '{sample: SAMPLE_MIN, sat: 1'b1};
    end else if (d_side[0]) begin
      res_nxt = '{sample: SAMPLE_MAX, sat: 1'b1};
    end else if (x_w > 49'(SAMPLE_MAX)) begin
      res_nxt = '{sample: SAMPLE_MAX, sat: 1'b1};
    end else if (x_w < 49'(SAMPLE_MIN)) begin
      res_nxt = '{sample: SAMPLE_MIN, sat: 1'b1};
    end else begin
      res_nxt = '{sample: x_w[31:0], sat: 1'b0};
    end
  end

  // Two-entry queue parts the pipeline from the output handshake.
  assign push = en && d_vld;
  assign pop  = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= res_nxt;
    end
  end

  assign out_valid        = (cnt_r != 2'd0);
  assign out_sample_value = $signed(q_r[rd_r].sample);
  assign out_saturated    = q_r[rd_r].sat;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output queue count out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (cnt_r == 2'd2 && d_vld)) else $error("stall without a full queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> cnt_r != 2'd2) else $error("transaction pushed into a full queue");

  a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_sample_value == SAMPLE_MAX || out_sample_value == SAMPLE_MIN))
    else $error("saturated result not at a range limit");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("queue count did not follow a pop");

endmodule

/* sim/moyal_sample_checker.sv */
// Checker for the Moyal sampler: tracks the registers, predicts each sample and compares.
module moyal_sample_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [31:0]                    in_uniform_fraction,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [31:0]             out_sample_value,
  input  logic                           out_saturated,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mics_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending_count
);
  import mics_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic               clipped;
  } sample_t;

  localparam logic signed [63:0] LN2_FIX   = 64'sd2977044472;
  localparam logic signed [63:0] TAIL_EDGE = 64'sd26306674688;

  localparam logic signed [63:0] CENTRE_POLY [10] = '{
    64'sh175c000 << 4,  64'sh133b402 << 9,  64'sh1499232 << 12,
    64'sh1e52cd2 << 8,  -(64'sh1d70bd0 << 17), -(64'sh135be90 << 19),
    64'sh12f6400 << 23, 64'sh17a1e50 << 25, -(64'sh1db2aee << 29),
    64'sh1c5bf88 << 31
  };
  localparam logic signed [63:0] TAIL_POLY [9] = '{
    64'sh14deb44,       64'sh1f7c9ae << 6,  64'sh147e512 << 12,
    64'sh1dca7de << 16, 64'sh19cab92 << 20, 64'sh18cc0de << 23,
    64'sh13ca920 << 24, -(64'sh10eff66 << 30), 64'sh1ae16a4 << 31
  };

  logic signed [31:0] mu;
  logic [31:0]        sigma;
  sample_t            awaited_samples[$];
  int                 mismatches;

  assign pending_count = awaited_samples.size();
  assign fail_count    = mismatches;

  // Rounded (x * y) / 2^s on the full 128-bit product, half away from zero.
  function automatic logic signed [63:0] scaled_product(logic signed [63:0] x,
                                                        logic signed [63:0] y, int s);
    logic         neg;
    logic [63:0]  ax, ay, r;
    logic [127:0] prod;
    neg  = (x < 0) != (y < 0);
    ax   = x < 0 ? -x : x;
    ay   = y < 0 ? -y : y;
    prod = {64'd0, ax} * {64'd0, ay};
    prod = prod + (128'd1 << (s - 1));
    r    = 64'(prod >> s) & 64'h7fff_ffff_ffff_ffff;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] log2_fix(logic [63:0] v);
    int          e;
    logic [63:0] m, frac;
    if (v == 0) return 0;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m    = e >= 31 ? v >> (e - 31) : v << (31 - e);
    frac = 0;
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[31-i] = 1'b1;
      end
    end
    return $signed((64'(e) << 32) | frac);
  endfunction

  function automatic sample_t moyal_sample(logic [31:0] u);
    sample_t            res;
    logic signed [63:0] t, p, lg, lnv, x;
    res.clipped = 1'b0;
    if (u == 0) begin
      res.value   = SAMPLE_MIN;
      res.clipped = 1'b1;
      return res;
    end
    t = log2_fix(64'd1 * u) + log2_fix((64'd1 << 33) - u) - (64'sd64 <<< 32);
    t = scaled_product(t, LN2_FIX, 32);
    if (t < -TAIL_EDGE) begin
      p = TAIL_POLY[0];
      for (int i = 1; i < 9; i++) p = scaled_product(p, t, 32) + TAIL_POLY[i];
    end else begin
      p = CENTRE_POLY[0];
      for (int i = 1; i < 10; i++) p = scaled_product(p, t, 32) + CENTRE_POLY[i];
    end
    if (p <= 0) begin
      res.value   = SAMPLE_MAX;
      res.clipped = 1'b1;
      return res;
    end
    lg  = (64'sd1 <<< 31) + log2_fix((64'd1 << 32) - u) - (64'sd32 <<< 32)
        + log2_fix(p) - (64'sd56 <<< 32);
    lnv = scaled_product(lg, LN2_FIX, 32);
    x   = 64'(mu) - scaled_product($signed({32'd0, sigma}), lnv, 31);
    if (x > 64'(SAMPLE_MAX)) begin
      res.value   = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (x < 64'(SAMPLE_MIN)) begin
      res.value   = SAMPLE_MIN;
      res.clipped = 1'b1;
    end else begin
      res.value = x[31:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    sample_t exp_s;
    if (!rst_n) begin
      mu    = 0;
      sigma = 32'd1 << 16;
      awaited_samples.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOCATION: mu = cfg_data;
          REG_SCALE:    sigma = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited_samples.push_back(moyal_sample(in_uniform_fraction));
      if (out_valid && out_ready) begin
        if (awaited_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sample %h sat %b", out_sample_value, out_saturated);
        end else begin
          exp_s = awaited_samples.pop_front();
          if (exp_s.value !== out_sample_value || exp_s.clipped !== out_saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample mismatch: expected %h sat %b, got %h sat %b",
                       exp_s.value, exp_s.clipped, out_sample_value, out_saturated);
          end
        end
      end
    end
  end

endmodule

/* sim/tb_moyal_inverse_cdf_sampler.sv */
// Testbench top of the Moyal sampler: clock, reset, stimulus and the verdict.
module tb_moyal_inverse_cdf_sampler;
  import mics_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  logic                 clk, rst_n;
  logic                 in_valid, in_ready, out_valid, out_ready, out_saturated;
  logic [31:0]          in_uniform_fraction, cfg_data;
  logic signed [31:0]   out_sample_value;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  int                   fail_count, pending_count;
  logic                 in_fire, cfg_fire;
  int                   burst_left, cycles, stall_left, ready_mode;

  moyal_inverse_cdf_sampler dut (.*);

  moyal_sample_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_fire  <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    cycles   <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver switches between always ready, random stalls, periodic stalls and runs of stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (cycles % 97 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cycles % 5) != 0;
        default: begin
          if (stall_left == 0) stall_left = $urandom_range(1, 8);
          stall_left--;
          out_ready <= stall_left == 0;
        end
      endcase
    end
  end

  // A burst keeps in_valid high from one transaction to the next.
  task automatic push_fraction(input logic [31:0] u);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid            <= 1'b1;
    in_uniform_fraction <= u;
    do @(negedge clk); while (!in_fire);
    burst_left--;
  endtask

  // Stop sending and let every outstanding sample come back before going on.
  task automatic drain;
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_fraction();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5:       return $urandom_range(1, 5000000);
      6:          return 32'hffff_ffff - $urandom_range(0, 1 << 20);
      7:          return $urandom_range(1, 1000);
      8:          return $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                              : ~(32'd1 << $urandom_range(0, 31));
      default:    return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
    endcase
  endfunction

  initial begin
    logic [31:0] directed_fractions[$] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'hffff_ffff, 32'hffff_fffe, 32'h8000_0000,
      32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'd4700000, 32'd4720000,
      32'd4740000, 32'd100000, 32'h0000_ffff, 32'hffff_0000, 32'h0001_0000
    };
    logic signed [31:0] locations[7] = '{
      32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0001_0000, -32'sh0003_8000,
      32'sd0, 32'sd0
    };
    logic [31:0] scales[7] = '{
      32'h0001_0000, 32'hffff_ffff, 32'd1, 32'h0000_8000, 32'h0040_0000, 32'd0, 32'd0
    };
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_uniform_fraction = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    burst_left = 0;
    ready_mode = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_fractions[i]) push_fraction(directed_fractions[i]);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_reg(REG_LOCATION, ph == 6 ? $urandom() : locations[ph]);
        write_reg(REG_SCALE, ph == 6 ? $urandom() : scales[ph]);
        // An unknown register index must leave both registers alone.
        if (ph == 3) write_reg(CFG_IDX_W'(REG_SCALE + 1), $urandom());
      end
      for (int n = 0; n < 165; n++) begin
        push_fraction(random_fraction());
        // Hold the sender once until the pipeline is empty.
        if (ph == 2 && n == 80) drain();
      end
      drain();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
